>>> rtl/sdh_pkg.sv
// shared constants and codes for the sd spi host engine
`timescale 1ns / 1ps
package sdh_pkg;
	localparam int BlockBytes = 512;
	localparam int AddrW = $clog2(BlockBytes);

	typedef logic [2:0] func_t;
	localparam func_t FN_INIT  = 3'd0;
	localparam func_t FN_READ  = 3'd1;
	localparam func_t FN_WRITE = 3'd2;
	localparam func_t FN_BYTE  = 3'd3;
	localparam func_t FN_TICK  = 3'd4;
	localparam func_t FN_LOAD  = 3'd5;

	typedef logic [3:0] phase_t;
	localparam phase_t PH_IDLE   = 4'd0;
	localparam phase_t PH_PRE    = 4'd1;
	localparam phase_t PH_CMD0   = 4'd2;
	localparam phase_t PH_CMD8   = 4'd3;
	localparam phase_t PH_R7     = 4'd4;
	localparam phase_t PH_CMD55  = 4'd5;
	localparam phase_t PH_ACMD41 = 4'd6;
	localparam phase_t PH_CMD58  = 4'd7;
	localparam phase_t PH_OCR    = 4'd8;
	localparam phase_t PH_CMD17  = 4'd9;
	localparam phase_t PH_TOKEN  = 4'd10;
	localparam phase_t PH_DATA   = 4'd11;
	localparam phase_t PH_CRC    = 4'd12;
	localparam phase_t PH_CMD24  = 4'd13;
	localparam phase_t PH_WDATA  = 4'd14;
	localparam phase_t PH_BUSY   = 4'd15;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_BAD     = 2'd1;
	localparam status_t ST_TIMEOUT = 2'd2;
	localparam status_t ST_NOINIT  = 2'd3;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_NONE = 2'd0;
	localparam kind_t KIND_V1   = 2'd1;
	localparam kind_t KIND_V2   = 2'd2;
	localparam kind_t KIND_HC   = 2'd3;

	typedef logic [2:0] cfg_idx_t;
	localparam cfg_idx_t CFG_INIT_TO  = 3'd0;
	localparam cfg_idx_t CFG_TOKEN_TO = 3'd1;
	localparam cfg_idx_t CFG_BUSY_TO  = 3'd2;
	localparam cfg_idx_t CFG_RETRIES  = 3'd3;
	localparam cfg_idx_t CFG_POLL     = 3'd4;
	localparam cfg_idx_t CFG_PREAMBLE = 3'd5;

	localparam logic [7:0] CMD_START   = 8'h40;
	localparam logic [7:0] CRC_CMD0    = 8'h95;
	localparam logic [7:0] CRC_CMD8    = 8'h87;
	localparam logic [7:0] CRC_NONE    = 8'hFF;
	localparam logic [31:0] ARG_CMD8   = 32'h0000_01AA;
	localparam logic [31:0] ARG_HCS    = 32'h4000_0000;
	localparam logic [7:0] TOKEN_START = 8'hFE;
	localparam logic [7:0] FILLER      = 8'hFF;
	localparam logic [4:0] RESP_ACCEPT = 5'h05;
	localparam logic [7:0] ECHO_CHECK  = 8'hAA;
	localparam logic [11:0] MS_MAX     = 12'hFFF;
endpackage

>>> rtl/sdh_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module sdh_ram #(
	parameter int Width = 8,
	parameter int Depth = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

>>> rtl/sd_spi_card_host_engine.sv
// sd card spi-mode host engine, one byte exchange per beat
//  channel | dir | handshake             | payload
//  s_axis  | in  | s_tvalid / s_tready   | s_tuser func, s_tdata request fields
//  m_axis  | out | m_tvalid / m_tready   | m_tdata result fields
//  cfg     | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
// an input beat goes to an input register and is then decided into the result register;
// one beat per cycle sustained while no held result stalls the input register
// the sector buffer ram is read through its registered port from the next byte count
// reset clears the sequencer and the registers; buffer contents start unknown
// a held result stalls the input register only when that beat makes a result
`timescale 1ns / 1ps
module sd_spi_card_host_engine
	import sdh_pkg::*;
#(
	parameter int BLOCK_BYTES = sdh_pkg::BlockBytes
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [2:0]  s_tuser,   // func
	input  logic [63:0] s_tdata,   // sector, miso_byte, buffer_index, buffer_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	// mosi_byte, mosi_valid, cs_low, slow_clock, read_byte, read_valid,
	// read_index, done_res, status, card_kind
	output logic [39:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [11:0] cfg_data
);
	localparam int AW = $clog2(BLOCK_BYTES);
	localparam int CW = AW + 1;
	localparam logic [CW-1:0] BLK = CW'(BLOCK_BYTES);

	// config
	logic [11:0] init_to_q, token_to_q, busy_to_q;
	logic [3:0]  retries_q, poll_lim_q;
	logic [4:0]  pre_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_to_q <= 12'd1000; token_to_q <= 12'd200; busy_to_q <= 12'd500;
			retries_q <= 4'd5; poll_lim_q <= 4'd10; pre_q <= 5'd10;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_INIT_TO:  init_to_q  <= cfg_data;
				CFG_TOKEN_TO: token_to_q <= cfg_data;
				CFG_BUSY_TO:  busy_to_q  <= cfg_data;
				CFG_RETRIES:  retries_q  <= cfg_data[3:0];
				CFG_POLL:     poll_lim_q <= cfg_data[3:0];
				CFG_PREAMBLE: pre_q      <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// input register
	logic        v_s1;
	func_t       func_s1;
	logic [31:0] sector_s1;
	logic [7:0]  miso_s1, bbyte_s1;
	logic [AW-1:0] bidx_s1;
	logic        proceed, has_res;

	assign s_tready = !v_s1 || proceed;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (s_tready) v_s1 <= s_tvalid;
	end
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			func_s1   <= s_tuser;
			sector_s1 <= s_tdata[31:0];
			miso_s1   <= s_tdata[39:32];
			bidx_s1   <= s_tdata[40 +: AW];
			bbyte_s1  <= s_tdata[56:49];
		end
	end

	// sequencer state
	phase_t      phase_q, phase_d;
	kind_t       kind_q, kind_d;
	logic [9:0]  bc_q, bc_d;
	logic [47:0] frame_q, frame_d;
	logic [3:0]  poll_q, poll_d, retry_q, retry_d;
	logic [11:0] ms_q, ms_d;
	logic [31:0] cap_q, cap_d;
	logic        slow_q, slow_d;

	// buffer ram with same-edge write forwarding
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]    ram_wdata, ram_q, fwd_q, buf_byte;
	logic          hit_q;

	sdh_ram #(.Width(8), .Depth(BLOCK_BYTES)) u_buf (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_q)
	);
	assign ram_raddr = AW'(bc_d - 10'd2);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) hit_q <= 1'b0;
		else hit_q <= ram_we && ram_waddr == ram_raddr;
	end
	always_ff @(posedge clk) fwd_q <= ram_wdata;
	assign buf_byte = hit_q ? fwd_q : ram_q;

	// result fields
	logic [7:0]    o_mosi, o_rd;
	logic          o_mv, o_cs, o_done, o_rv;
	status_t       o_st;
	logic [AW-1:0] o_ridx;

	logic [3:0]  retries_eff, poll_eff;
	logic [4:0]  pre_eff;
	logic [31:0] addr;
	logic        is_cmd, fin;
	status_t     fin_st;
	logic [7:0]  cmd_byte;
	logic [4:0]  poll_inc;
	logic [CW-1:0] bc_inc;

	assign retries_eff = retries_q == 4'd0 ? 4'd1 : retries_q;
	assign poll_eff    = poll_lim_q == 4'd0 ? 4'd1 : poll_lim_q;
	assign pre_eff     = pre_q == 5'd0 ? 5'd1 : pre_q;
	assign poll_inc    = {1'b0, poll_q} + 5'd1;
	assign bc_inc      = bc_q[CW-1:0] + CW'(1);

	always_comb begin
		case (bc_q[2:0])
			3'd1: cmd_byte = frame_q[47:40];
			3'd2: cmd_byte = frame_q[39:32];
			3'd3: cmd_byte = frame_q[31:24];
			3'd4: cmd_byte = frame_q[23:16];
			3'd5: cmd_byte = frame_q[15:8];
			3'd6: cmd_byte = frame_q[7:0];
			default: cmd_byte = FILLER;
		endcase
		if (bc_q >= 10'd7) cmd_byte = FILLER;
	end

	always_comb begin
		phase_d = phase_q; kind_d = kind_q; bc_d = bc_q; frame_d = frame_q;
		poll_d = poll_q; retry_d = retry_q; ms_d = ms_q; cap_d = cap_q; slow_d = slow_q;
		has_res = 1'b0; fin = 1'b0; fin_st = ST_OK;
		o_mosi = FILLER; o_mv = 1'b1; o_cs = 1'b1; o_done = 1'b0; o_st = ST_OK;
		o_rd = 8'd0; o_rv = 1'b0; o_ridx = '0;
		ram_we = 1'b0; ram_waddr = bidx_s1; ram_wdata = bbyte_s1;
		addr = kind_q == KIND_HC ? sector_s1 : {sector_s1[31-AW:0], AW'(0)};
		is_cmd = phase_q == PH_CMD0 || phase_q == PH_CMD8 || phase_q == PH_CMD55 ||
			phase_q == PH_ACMD41 || phase_q == PH_CMD58 || phase_q == PH_CMD17 ||
			phase_q == PH_CMD24;
		if (v_s1) begin
			case (func_s1)
				FN_INIT: if (phase_q == PH_IDLE) begin
					has_res = 1'b1; kind_d = KIND_NONE; slow_d = 1'b1; phase_d = PH_PRE;
					bc_d = 10'd1; retry_d = 4'd0; o_cs = 1'b0;
				end
				FN_READ, FN_WRITE: if (phase_q == PH_IDLE) begin
					has_res = 1'b1; slow_d = 1'b0;
					if (kind_q == KIND_NONE) begin
						o_mosi = 8'd0; o_mv = 1'b0; o_cs = 1'b0; o_done = 1'b1; o_st = ST_NOINIT;
					end else begin
						phase_d = func_s1 == FN_READ ? PH_CMD17 : PH_CMD24;
						frame_d = {CMD_START | (func_s1 == FN_READ ? 8'd17 : 8'd24), addr,
							CRC_NONE};
						bc_d = 10'd1; poll_d = 4'd0;
					end
				end
				FN_TICK: if (ms_q != MS_MAX) ms_d = ms_q + 12'd1;
				FN_LOAD: ram_we = 1'b1;
				FN_BYTE: if (phase_q != PH_IDLE) begin
					has_res = 1'b1;
					slow_d = phase_q <= PH_OCR;
					if (is_cmd) begin
						if (bc_q < 10'd8 || (miso_s1[7] && poll_inc < {1'b0, poll_eff})) begin
							if (bc_q >= 10'd8) poll_d = poll_q + 4'd1;
							o_mosi = cmd_byte;
							if (bc_q < 10'd8) bc_d = bc_q + 10'd1;
						end else begin
							// r1 decision, default is a release byte after a new command
							o_cs = 1'b0; bc_d = 10'd0; poll_d = 4'd0;
							unique case (phase_q)
								PH_CMD0:
									if (miso_s1 == 8'h01) begin
										phase_d = PH_CMD8;
										frame_d = {CMD_START | 8'd8, ARG_CMD8, CRC_CMD8};
									end else if (retry_q < retries_eff) begin
										retry_d = retry_q + 4'd1;
										frame_d = {CMD_START, 32'd0, CRC_CMD0};
									end else begin
										fin = 1'b1; fin_st = ST_BAD;
									end
								PH_CMD8:
									if (miso_s1 == 8'h01) begin
										phase_d = PH_R7; cap_d = 32'd0; o_cs = 1'b1;
									end else if (miso_s1[2]) begin
										kind_d = KIND_V1; ms_d = 12'd0; phase_d = PH_CMD55;
										frame_d = {CMD_START | 8'd55, 32'd0, CRC_NONE};
									end else begin
										fin = 1'b1; fin_st = ST_BAD;
									end
								PH_CMD55:
									if (miso_s1 > 8'h01) begin
										fin = 1'b1; fin_st = ST_BAD;
									end else begin
										phase_d = PH_ACMD41;
										frame_d = {CMD_START | 8'd41,
											kind_q == KIND_V1 ? 32'd0 : ARG_HCS, CRC_NONE};
									end
								PH_ACMD41:
									if (miso_s1 == 8'h00) begin
										if (kind_q == KIND_V1) fin = 1'b1;
										else begin
											phase_d = PH_CMD58;
											frame_d = {CMD_START | 8'd58, 32'd0, CRC_NONE};
										end
									end else if (ms_q > init_to_q) begin
										fin = 1'b1; fin_st = ST_TIMEOUT;
									end else begin
										phase_d = PH_CMD55;
										frame_d = {CMD_START | 8'd55, 32'd0, CRC_NONE};
									end
								PH_CMD58:
									if (miso_s1 == 8'h00) begin
										phase_d = PH_OCR; cap_d = 32'd0; o_cs = 1'b1;
									end else fin = 1'b1;
								PH_CMD17:
									if (miso_s1 != 8'h00) begin
										fin = 1'b1; fin_st = ST_BAD;
									end else begin
										phase_d = PH_TOKEN; ms_d = 12'd0; o_cs = 1'b1;
									end
								default:
									if (miso_s1 != 8'h00) begin
										fin = 1'b1; fin_st = ST_BAD;
									end else begin
										phase_d = PH_WDATA; bc_d = 10'd1; o_cs = 1'b1;
									end
							endcase
						end
					end else begin
						case (phase_q)
							PH_PRE:
								if (bc_q < {5'd0, pre_eff}) begin
									bc_d = bc_q + 10'd1; o_cs = 1'b0;
								end else begin
									retry_d = 4'd1; phase_d = PH_CMD0;
									frame_d = {CMD_START, 32'd0, CRC_CMD0};
									bc_d = 10'd1; poll_d = 4'd0;
								end
							PH_R7, PH_OCR: begin
								cap_d = {cap_q[23:0], miso_s1};
								bc_d = bc_q + 10'd1;
								if (bc_q >= 10'd3) begin
									if (phase_q == PH_R7) begin
										if (cap_q[7:0] != 8'h01 || miso_s1 != ECHO_CHECK) begin
											fin = 1'b1; fin_st = ST_BAD;
										end else begin
											kind_d = KIND_V2; ms_d = 12'd0; phase_d = PH_CMD55;
											frame_d = {CMD_START | 8'd55, 32'd0, CRC_NONE};
											bc_d = 10'd0; poll_d = 4'd0; o_cs = 1'b0;
										end
									end else begin
										if (cap_q[22]) kind_d = KIND_HC;
										fin = 1'b1;
									end
								end
							end
							PH_TOKEN:
								if (miso_s1 == FILLER) begin
									if (ms_q > token_to_q) begin
										fin = 1'b1; fin_st = ST_TIMEOUT;
									end
								end else if (miso_s1 != TOKEN_START) begin
									fin = 1'b1; fin_st = ST_BAD;
								end else begin
									phase_d = PH_DATA; bc_d = 10'd0;
								end
							PH_DATA: begin
								ram_we = 1'b1; ram_waddr = bc_q[AW-1:0]; ram_wdata = miso_s1;
								o_rd = miso_s1; o_rv = 1'b1; o_ridx = bc_q[AW-1:0];
								bc_d = bc_q + 10'd1;
								if (bc_inc >= BLK) begin
									phase_d = PH_CRC; bc_d = 10'd0;
								end
							end
							PH_CRC:
								if (bc_q == 10'd0) bc_d = 10'd1;
								else fin = 1'b1;
							PH_WDATA:
								if (bc_q <= 10'(BLOCK_BYTES + 4)) begin
									if (bc_q == 10'd1) o_mosi = TOKEN_START;
									else if (bc_q >= 10'd2 && bc_q < 10'(BLOCK_BYTES + 2))
										o_mosi = buf_byte;
									bc_d = bc_q + 10'd1;
								end else if (miso_s1[4:0] != RESP_ACCEPT) begin
									fin = 1'b1; fin_st = ST_BAD;
								end else begin
									phase_d = PH_BUSY; ms_d = 12'd0;
								end
							default:
								if (miso_s1 != FILLER) begin
									if (ms_q > busy_to_q) begin
										fin = 1'b1; fin_st = ST_TIMEOUT;
									end
								end else fin = 1'b1;
						endcase
					end
					if (fin) begin
						phase_d = PH_IDLE; o_mosi = FILLER; o_mv = 1'b1; o_cs = 1'b0;
						o_done = 1'b1; o_st = fin_st;
						if (slow_d && fin_st != ST_OK) kind_d = KIND_NONE;
					end
				end
				default: ;
			endcase
		end
		if (!proceed) begin
			phase_d = phase_q; kind_d = kind_q; bc_d = bc_q; frame_d = frame_q;
			poll_d = poll_q; retry_d = retry_q; ms_d = ms_q; cap_d = cap_q;
			slow_d = slow_q; ram_we = 1'b0;
		end
	end

	assign proceed = v_s1 && (!has_res || !m_tvalid || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; kind_q <= KIND_NONE; bc_q <= '0; frame_q <= '0;
			poll_q <= '0; retry_q <= '0; ms_q <= '0; cap_q <= '0; slow_q <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			phase_q <= phase_d; kind_q <= kind_d; bc_q <= bc_d; frame_q <= frame_d;
			poll_q <= poll_d; retry_q <= retry_d; ms_q <= ms_d; cap_q <= cap_d;
			slow_q <= slow_d;
			if (proceed && has_res) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proceed && has_res)
			m_tdata <= {6'd0, kind_d, o_st, o_done, 9'(o_ridx), o_rv, o_rd, slow_d, o_cs,
				o_mv, o_mosi};
	end

	// the input register always drains when it holds nothing
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n) !v_s1 |-> s_tready)
		else $error("input stalled while empty");
	// write data count never runs past the response byte
	a_wdata_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_WDATA |-> bc_q <= 10'(BLOCK_BYTES + 5))
		else $error("write byte count overran");
	// read and write transfers run at the fast clock
	a_fast_clock: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q >= PH_CMD17 |-> !slow_q)
		else $error("slow clock during block transfer");
	// a held result does not move
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");
endmodule
